// File: hw/rtl/sgcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial gain command parser package
// Shared constants, status codes and the line record passed from the front
// part to the back part through the queue.
// ----------------------------------------------------------------------------
package sgcp_pkg;

  localparam int LINE_MAX  = 256;
  localparam int LEN_W     = $clog2(LINE_MAX + 1);
  localparam int WIN_DEPTH = 7;
  localparam int VALUE_W   = 23;
  localparam int PARAM_W   = 3;

  localparam logic [7:0] END_BYTE    = 8'h21;
  localparam logic [7:0] EQUALS_BYTE = 8'h3D;
  localparam logic [7:0] MINUS_BYTE  = 8'h2D;
  localparam logic [7:0] ZERO_BYTE   = 8'd48;

  typedef enum logic [1:0] {
    ST_UPDATE   = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef logic [WIN_DEPTH-1:0][7:0] window_t;

  typedef struct packed {
    status_t             status;
    logic [PARAM_W-1:0]  param_select;
    window_t             window;
    logic [LEN_W-1:0]    count;
  } line_rec_t;

endpackage
`default_nettype wire

// File: hw/rtl/sgcp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial gain command parser, front part
// Collects one line byte by byte, keeps the number field window and, on the
// end byte, classifies the line and writes one record into the queue.
// ----------------------------------------------------------------------------
module sgcp_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_byte,
  output logic                    in_ready,
  input  wire logic               q_full,
  output logic                    q_push,
  output sgcp_pkg::line_rec_t     q_rec
);

  logic [sgcp_pkg::LEN_W-1:0] line_length;
  logic [7:0]                 command_letter;
  sgcp_pkg::window_t          window;
  logic [sgcp_pkg::LEN_W-1:0] win_count;
  logic                       overflowed;

  logic                       fire;
  logic                       at_limit;
  logic                       ovf_now;
  logic [7:0]                 letter;
  logic                       letter_ok;
  logic [sgcp_pkg::PARAM_W-1:0] letter_code;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign at_limit = (line_length >= sgcp_pkg::LEN_W'(sgcp_pkg::LINE_MAX));
  assign ovf_now  = overflowed || at_limit;
  assign letter   = (line_length == '0) ? in_byte : command_letter;

  always_comb begin
    letter_ok   = 1'b1;
    letter_code = '0;
    case (letter)
      "P":     letter_code = 3'd0;
      "I":     letter_code = 3'd1;
      "D":     letter_code = 3'd2;
      "T":     letter_code = 3'd3;
      "p":     letter_code = 3'd4;
      "i":     letter_code = 3'd5;
      "d":     letter_code = 3'd6;
      "t":     letter_code = 3'd7;
      default: letter_ok   = 1'b0;
    endcase
  end

  // Before any '=' the window is the line prefix and its count equals the line
  // length; an '=' restarts both, so one window serves either case.
  always_comb begin
    q_push = fire && (in_byte == sgcp_pkg::END_BYTE);
    q_rec  = '{status: sgcp_pkg::ST_UPDATE, param_select: letter_code,
               window: window, count: win_count};
    if (ovf_now) begin
      q_rec.status       = sgcp_pkg::ST_OVERFLOW;
      q_rec.param_select = '0;
    end else if (!letter_ok) begin
      q_rec.status       = sgcp_pkg::ST_UNKNOWN;
      q_rec.param_select = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      command_letter <= '0;
      win_count      <= '0;
      overflowed     <= 1'b0;
    end else if (fire) begin
      if (in_byte == sgcp_pkg::END_BYTE) begin
        line_length    <= '0;
        command_letter <= '0;
        win_count      <= '0;
        overflowed     <= 1'b0;
      end else begin
        if (at_limit) begin
          overflowed <= 1'b1;
        end else begin
          if (line_length == '0) begin
            command_letter <= in_byte;
          end
          line_length <= line_length + 1'b1;
        end
        if (!ovf_now) begin
          if (in_byte == sgcp_pkg::EQUALS_BYTE) begin
            win_count <= '0;
          end else begin
            win_count <= win_count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !ovf_now && (in_byte != sgcp_pkg::END_BYTE) &&
        (in_byte != sgcp_pkg::EQUALS_BYTE) &&
        (win_count < sgcp_pkg::LEN_W'(sgcp_pkg::WIN_DEPTH))) begin
      window[win_count[2:0]] <= in_byte;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sgcp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial gain command parser, line record queue
// Two-entry queue that lets the front and back parts stall independently.
// ----------------------------------------------------------------------------
module sgcp_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sgcp_pkg::line_rec_t push_rec,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output sgcp_pkg::line_rec_t      head_rec
);

  sgcp_pkg::line_rec_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head_rec  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sgcp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial gain command parser, back part
// Decodes the number field of a queued line into hundredths and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
module sgcp_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rec_valid,
  input  wire sgcp_pkg::line_rec_t         rec,
  output logic                             rec_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sgcp_pkg::PARAM_W-1:0]     param_select,
  output logic [sgcp_pkg::VALUE_W-1:0]     value_hundredths,
  output sgcp_pkg::status_t                status
);

  logic                       neg;
  logic [sgcp_pkg::LEN_W-1:0] len;
  logic [7:0]                 sel [6];
  logic signed [24:0]         dg  [6];
  logic signed [24:0]         mag;
  logic signed [24:0]         signed_val;

  assign rec_pop = rec_valid && (!out_valid || out_ready);

  assign neg = (rec.count != '0) && (rec.window[0] == sgcp_pkg::MINUS_BYTE);
  assign len = rec.count - sgcp_pkg::LEN_W'(neg);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sel[k] = neg ? rec.window[k+1] : rec.window[k];
      dg[k]  = $signed({17'd0, sel[k]}) - $signed({17'd0, sgcp_pkg::ZERO_BYTE});
    end
  end

  always_comb begin
    case (len)
      sgcp_pkg::LEN_W'(4): mag = dg[0] * 25'sd100 + dg[2] * 25'sd10 + dg[3];
      sgcp_pkg::LEN_W'(5): mag = dg[0] * 25'sd1000 + dg[1] * 25'sd100 +
                                 dg[3] * 25'sd10 + dg[4];
      sgcp_pkg::LEN_W'(6): mag = dg[0] * 25'sd10000 + dg[1] * 25'sd1000 +
                                 dg[2] * 25'sd100 + dg[4] * 25'sd10 + dg[5];
      default:             mag = '0;
    endcase
    signed_val = neg ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      param_select <= rec.param_select;
      status       <= rec.status;
      if (rec.status == sgcp_pkg::ST_UPDATE) begin
        value_hundredths <= signed_val[sgcp_pkg::VALUE_W-1:0];
      end else begin
        value_hundredths <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/serial_gain_command_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial gain command parser
// Parses '!'-terminated gain command lines from a received byte stream and
// emits one result per line: parameter select, value in hundredths, status.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained while the output is taken,
// including a '!' in every cycle; s_tready drops when the queue is full.
// A line's record is written into the queue at the '!' transfer and then
// decoded into the output register once that register is free or taken.
// The two-entry queue absorbs short output stalls before input backpressure.
// Reset (rst, synchronous) empties the queue and output and starts a new line.
module serial_gain_command_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [2:0] param_select, [25:3] value_hundredths,
                                      // [27:26] status, [31:28] zero
);

  logic                            q_full;
  logic                            q_push;
  sgcp_pkg::line_rec_t             q_in_rec;
  logic                            q_pop;
  logic                            q_not_empty;
  sgcp_pkg::line_rec_t             q_head_rec;
  logic [sgcp_pkg::PARAM_W-1:0]    param_select;
  logic [sgcp_pkg::VALUE_W-1:0]    value_hundredths;
  sgcp_pkg::status_t               status;

  sgcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_in_rec)
  );

  sgcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (q_in_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (q_head_rec)
  );

  sgcp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .rec_valid        (q_not_empty),
    .rec              (q_head_rec),
    .rec_pop          (q_pop),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .param_select     (param_select),
    .value_hundredths (value_hundredths),
    .status           (status)
  );

  assign m_tdata = {4'b0000, status, value_hundredths, param_select};

endmodule
`default_nettype wire

// File: dv/tb_serial_gain_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for serial_gain_command_parser
// Streams command lines into the parser, predicts each line's result with a
// behavioral model of the line buffer and the number decoder, and checks
// every result transfer field by field. Directed lines cover each command
// letter, the field formats, the extreme digit bytes, unknown letters and
// the line length limit. Random lines follow, and the output is held off
// for a long stretch so that the parser has to stall its input.
// ----------------------------------------------------------------------------
module tb_serial_gain_command_parser;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_BYTES = 200;
  localparam logic [7:0] POINT_BYTE = ".";
  // The index into this table is the parameter select code.
  localparam logic [7:0] SEL_LETTER [8] = '{"P", "I", "D", "T", "p", "i", "d", "t"};

  typedef struct {
    logic [sgcp_pkg::PARAM_W-1:0] param_select;
    logic [sgcp_pkg::VALUE_W-1:0] value;
    sgcp_pkg::status_t            status;
  } gain_update_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  // Line state of the parser model.
  int unsigned       line_len;
  logic [7:0]        cmd_letter;
  sgcp_pkg::window_t prefix_win;
  sgcp_pkg::window_t field_win;
  int unsigned       field_count;
  bit                eq_seen;
  bit                line_ovf;

  gain_update_t pending_updates[$];

  int mismatches;
  int results_checked;
  int bytes_sent;
  int lines_sent;
  int status_count [3];
  int burst_left;
  int idle_cycles;
  int hold_left;
  bit sender_steady;
  bit recv_steady;
  bit hold_req;
  bit hold_ack;
  bit ready_level;
  int ready_run;

  serial_gain_command_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic clear_line_state();
    line_len    = 0;
    cmd_letter  = 8'h00;
    prefix_win  = '0;
    field_win   = '0;
    field_count = 0;
    eq_seen     = 1'b0;
    line_ovf    = 1'b0;
  endtask

  function automatic int digit_at(sgcp_pkg::window_t w, int pos);
    if (pos >= sgcp_pkg::WIN_DEPTH) return 0;
    return int'(w[pos]) - int'(sgcp_pkg::ZERO_BYTE);
  endfunction

  // Fields d.dd, dd.dd and ddd.dd after an optional minus; the point byte is skipped.
  function automatic int field_hundredths(sgcp_pkg::window_t w, int unsigned count);
    int          s;
    int unsigned n;
    bit          neg;
    int          v;
    s   = 0;
    n   = count;
    neg = 1'b0;
    v   = 0;
    if (count >= 1 && w[0] == sgcp_pkg::MINUS_BYTE) begin
      neg = 1'b1;
      s   = 1;
      n   = count - 1;
    end
    case (n)
      4: v = digit_at(w, s) * 100 + digit_at(w, s + 2) * 10 + digit_at(w, s + 3);
      5: v = digit_at(w, s) * 1000 + digit_at(w, s + 1) * 100 + digit_at(w, s + 3) * 10 +
             digit_at(w, s + 4);
      6: v = digit_at(w, s) * 10000 + digit_at(w, s + 1) * 1000 + digit_at(w, s + 2) * 100 +
             digit_at(w, s + 4) * 10 + digit_at(w, s + 5);
      default: v = 0;
    endcase
    return neg ? -v : v;
  endfunction

  function automatic int select_code(logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (SEL_LETTER[i] == c) return i;
    end
    return -1;
  endfunction

  task automatic predict_byte(logic [7:0] b);
    gain_update_t r;
    int           code;
    int           v;
    if (line_len >= sgcp_pkg::LINE_MAX) begin
      line_ovf = 1'b1;
    end else begin
      if (line_len == 0) cmd_letter = b;
      line_len++;
    end
    if (b != sgcp_pkg::END_BYTE) begin
      if (!line_ovf) begin
        if (line_len - 1 < sgcp_pkg::WIN_DEPTH) prefix_win[line_len - 1] = b;
        if (b == sgcp_pkg::EQUALS_BYTE) begin
          eq_seen     = 1'b1;
          field_count = 0;
          field_win   = '0;
        end else if (eq_seen) begin
          if (field_count < sgcp_pkg::WIN_DEPTH) field_win[field_count] = b;
          field_count++;
        end
      end
    end else begin
      r.param_select = '0;
      r.value        = '0;
      code           = select_code(cmd_letter);
      if (line_ovf) begin
        r.status = sgcp_pkg::ST_OVERFLOW;
      end else if (code < 0) begin
        r.status = sgcp_pkg::ST_UNKNOWN;
      end else begin
        r.status       = sgcp_pkg::ST_UPDATE;
        r.param_select = code[sgcp_pkg::PARAM_W-1:0];
        v = eq_seen ? field_hundredths(field_win, field_count)
                    : field_hundredths(prefix_win, line_len - 1);
        r.value = v[sgcp_pkg::VALUE_W-1:0];
      end
      pending_updates.push_back(r);
      status_count[int'(r.status)]++;
      lines_sent++;
      clear_line_state();
    end
  endtask

  // Offers one byte and returns at the edge where the transfer happens.
  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0 && !sender_steady) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_text(string t);
    for (int i = 0; i < t.len(); i++) send_byte(t[i]);
  endtask

  // Six bytes shaped like ddd.dd, all digits the same byte.
  task automatic send_flat_field(logic [7:0] d);
    for (int i = 0; i < 6; i++) send_byte(i == 3 ? POINT_BYTE : d);
  endtask

  function automatic logic [7:0] text_byte(bit no_equals);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == sgcp_pkg::END_BYTE || (no_equals && b == sgcp_pkg::EQUALS_BYTE));
    return b;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", results_checked, what, got, want);
    mismatches++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    gain_update_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("arrived with nothing pending, tdata", int'(m_tdata), 0);
      end else begin
        want = pending_updates.pop_front();
        if (m_tdata[2:0] != want.param_select)
          report_mismatch("param_select", int'(m_tdata[2:0]), int'(want.param_select));
        if (m_tdata[25:3] != want.value)
          report_mismatch("value_hundredths", int'($signed(m_tdata[25:3])),
                          int'($signed(want.value)));
        if (m_tdata[27:26] != want.status)
          report_mismatch("status", int'(m_tdata[27:26]), int'(want.status));
        if (m_tdata[31:28] != 4'd0)
          report_mismatch("pad bits", int'(m_tdata[31:28]), 0);
      end
      results_checked++;
    end
  end

  // Output side: a run-length stall pattern, a steady mode and a long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (recv_steady) begin
      m_tready <= 1'b1;
    end else begin
      if (ready_run == 0) begin
        ready_level = !ready_level;
        ready_run = ready_level ? $urandom_range(1, 10) : $urandom_range(1, 5);
      end else begin
        ready_run--;
      end
      m_tready <= ready_level;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("No transfer for %0d cycles, %0d results outstanding.", STALL_LIMIT,
                 pending_updates.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed_lines();
    send_text("P=1.23!");
    send_text("I=12.34!");
    send_text("D=123.45!");
    send_text("T=-1.23!");
    send_text("p=-12.34!");
    send_text("i=-123.45!");
    send_text("d=0.00!");
    send_text("t=999.99!");
    send_text("!");
    send_text("X=1.23!");
    send_text("P=1.2!");
    send_text("P=1234567!");
    send_text("P=-!");
    send_text("I=9.99=45.67!");
    send_text("D12.34!");
    send_text("-1.23!");
    send_text("==1.23!");
    send_text("p=x.yz!");
    // Largest and smallest digit bytes give the extremes of the value range.
    send_text("t=");
    send_flat_field(8'hFF);
    send_byte(sgcp_pkg::END_BYTE);
    send_text("T=-");
    send_flat_field(8'hFF);
    send_byte(sgcp_pkg::END_BYTE);
    send_text("P=");
    send_flat_field(8'h00);
    send_byte(sgcp_pkg::END_BYTE);
  endtask

  // Lines of exactly the maximum length and one byte over.
  task automatic test_line_limit();
    for (int extra = 0; extra < 2; extra++) begin
      send_byte(SEL_LETTER[$urandom_range(0, 7)]);
      repeat (249 + extra) send_byte(text_byte(1'b1));
      send_text("=1.23!");
    end
    send_text("i=-4.56!");
  endtask

  // Hold the output off while many short lines are offered.
  task automatic test_output_hold();
    hold_req = !hold_req;
    repeat (10) send_byte(sgcp_pkg::END_BYTE);
    send_text("T=98.76!");
    send_text("p=5.43!");
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_line();
    int ndig;
    int point_at;
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 9) != 0) send_byte(SEL_LETTER[$urandom_range(0, 7)]);
      else send_byte(text_byte(1'b1));
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_byte(text_byte(1'b1));
      if ($urandom_range(0, 9) != 0) send_byte(sgcp_pkg::EQUALS_BYTE);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(0, 9)) send_byte(text_byte(1'b1));
        send_byte(sgcp_pkg::EQUALS_BYTE);
      end
      if ($urandom_range(0, 2) == 0) send_byte(sgcp_pkg::MINUS_BYTE);
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(4, 6);
      point_at = ndig - 3;
      for (int i = 0; i < ndig; i++) begin
        if (i == point_at) send_byte(POINT_BYTE);
        else if ($urandom_range(0, 19) == 0) send_byte(text_byte(1'b1));
        else send_byte(sgcp_pkg::ZERO_BYTE + 8'($urandom_range(0, 9)));
      end
    end else begin
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(sgcp_pkg::END_BYTE);
  endtask

  task automatic test_random_traffic();
    int first_byte;
    int line_no;
    first_byte = bytes_sent;
    line_no    = 0;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      if (line_no % 12 == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        recv_steady   = ($urandom_range(0, 3) == 0);
      end
      send_random_line();
      line_no++;
    end
    sender_steady = 1'b0;
    recv_steady   = 1'b0;
  endtask

  initial begin
    clear_line_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_lines();
    test_line_limit();
    test_output_hold();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d lines: %0d updates, %0d unknown letters, %0d overflows.",
             bytes_sent, lines_sent, status_count[0], status_count[1], status_count[2]);
    $display("Checked %0d results with %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sgcp_pkg.sv
hw/rtl/sgcp_front.sv
hw/rtl/sgcp_queue.sv
hw/rtl/sgcp_back.sv
hw/rtl/serial_gain_command_parser.sv
dv/tb_serial_gain_command_parser.sv
